@@ sv/pvd_pkg.sv @@
// Shared constants, types and helpers for the packet validate/decode block
`timescale 1ns / 1ps
`default_nettype none

package pvd_pkg;

  localparam logic [7:0] MAGIC_BYTE = 8'h03;
  localparam logic [7:0] LEVEL_ONE  = 8'h01;
  localparam logic [7:0] LEVEL_TWO  = 8'h02;
  localparam logic [2:0] HEADER_LEN = 3'd6;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISMATCH   = 3'd1,
    ST_LEVEL_HIGH = 3'd2,
    ST_BOGUS      = 3'd3,
    ST_UNCHECKED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       status_valid;
    status_t    status;
    logic [7:0] level;
  } pvd_result_t;

  // Rotate a byte right by k places
  function automatic logic [7:0] rotate_right(input logic [7:0] b, input logic [2:0] k);
    logic [15:0] twice;
    twice = {b, b} >> k;
    return twice[7:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/pvd_check.sv @@
// Per-packet state and checking logic: header capture, checksum, rotate decode
`timescale 1ns / 1ps
`default_nettype none

module pvd_check import pvd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output pvd_result_t      res
);

  logic [2:0]  header_count_r, header_count_nxt;
  logic [2:0]  rotate_phase_r, rotate_phase_nxt;
  logic [1:0]  word_phase_r,   word_phase_nxt;
  logic        magic_seen_r,   magic_seen_nxt;
  logic [7:0]  level_r,        level_nxt;
  logic [31:0] expected_sum_r, expected_sum_nxt;
  logic [31:0] running_sum_r,  running_sum_nxt;
  logic [23:0] partial_word_r, partial_word_nxt;

  logic [31:0] addend;
  logic [31:0] sum_upd;
  logic [1:0]  lane;
  logic        in_payload;

  always_comb begin
    header_count_nxt = (header_count_r < HEADER_LEN) ? header_count_r + 3'd1 : header_count_r;
    rotate_phase_nxt = rotate_phase_r + 3'd1;
    word_phase_nxt   = word_phase_r;
    magic_seen_nxt   = magic_seen_r;
    level_nxt        = level_r;
    expected_sum_nxt = expected_sum_r;
    running_sum_nxt  = running_sum_r;
    partial_word_nxt = partial_word_r;
    in_payload       = (header_count_r == HEADER_LEN);
    lane             = header_count_r[1:0] - 2'd2;

    // whole word on the fourth byte, lone tail byte on the first two
    unique case (word_phase_r)
      2'd3:    addend = {data_byte, partial_word_r};
      2'd2:    addend = '0;
      default: addend = {24'd0, data_byte};
    endcase
    sum_upd = running_sum_r + addend;

    res.out_byte     = data_byte;
    res.status_valid = last_byte;
    res.status       = ST_OK;
    res.level        = '0;

    if (header_count_r == 3'd0) begin
      magic_seen_nxt = (data_byte == MAGIC_BYTE);
    end else if (header_count_r == 3'd1) begin
      level_nxt = data_byte;
    end else begin
      if (magic_seen_r && level_r == LEVEL_TWO) begin
        res.out_byte = rotate_right(data_byte, rotate_phase_r);
      end
      if (!in_payload) begin
        expected_sum_nxt[lane*8 +: 8] = data_byte;
      end else begin
        if (word_phase_r == 2'd3) begin
          running_sum_nxt  = sum_upd;
          partial_word_nxt = '0;
        end else begin
          partial_word_nxt[word_phase_r*8 +: 8] = data_byte;
        end
        word_phase_nxt = word_phase_r + 2'd1;
      end
    end

    if (last_byte) begin
      res.level = level_nxt;
      priority if (!magic_seen_nxt || header_count_r < HEADER_LEN - 3'd1) begin
        res.status = ST_BOGUS;
      end else if (level_r == 8'd0) begin
        res.status = ST_OK;
      end else if (level_r == LEVEL_ONE) begin
        // a bare header checks against itself
        if (!in_payload) res.status = ST_OK;
        else res.status = (sum_upd == expected_sum_r) ? ST_OK : ST_MISMATCH;
      end else if (level_r == LEVEL_TWO) begin
        res.status = ST_UNCHECKED;
      end else begin
        res.status = ST_LEVEL_HIGH;
      end
      header_count_nxt = '0;
      rotate_phase_nxt = '0;
      word_phase_nxt   = '0;
      magic_seen_nxt   = 1'b0;
      level_nxt        = '0;
      expected_sum_nxt = '0;
      running_sum_nxt  = '0;
      partial_word_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= '0;
      rotate_phase_r <= '0;
      word_phase_r   <= '0;
      magic_seen_r   <= 1'b0;
      level_r        <= '0;
      expected_sum_r <= '0;
      running_sum_r  <= '0;
      partial_word_r <= '0;
    end else if (step) begin
      header_count_r <= header_count_nxt;
      rotate_phase_r <= rotate_phase_nxt;
      word_phase_r   <= word_phase_nxt;
      magic_seen_r   <= magic_seen_nxt;
      level_r        <= level_nxt;
      expected_sum_r <= expected_sum_nxt;
      running_sum_r  <= running_sum_nxt;
      partial_word_r <= partial_word_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/packet_validate_decode.sv @@
// Top level of the byte-serial packet validator and level-2 decoder
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                          Handshake
// input     in         in_data_byte, in_last_byte                     in_valid / in_stall
// result    out        out_byte, out_status_valid, out_status,        out_valid / out_stall
//                      out_level
//
// One byte per cycle sustained while the result side does not stall: each byte moves
// through an input register, then the checker logic (one 32-bit add and compare, a byte
// rotate) into the result register, which presents the byte's result.
// Synchronous active-low reset empties both registers and clears packet state.
// A stall on the result side holds the result register and then the input
// register; the input channel stalls only when both are full.

module packet_validate_decode import pvd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_status_valid,
  output logic [2:0]      out_status,
  output logic [7:0]      out_level
);

  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_last_r;
  logic        out_valid_r;
  pvd_result_t out_res_r;
  pvd_result_t chk_res;
  logic        out_move;
  logic        s1_fire;
  logic        in_accept;

  // Advance the result register when it is empty or being taken
  assign out_move  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_move;
  assign in_stall  = s1_valid_r && !out_move;
  assign in_accept = in_valid && !in_stall;

  // Input register: capture each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Packet state advances only when the byte leaves for the result register
  pvd_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .res       (chk_res)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= chk_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_res_r.out_byte;
  assign out_status_valid = out_res_r.status_valid;
  assign out_status       = out_res_r.status;
  assign out_level        = out_res_r.level;

endmodule

`default_nettype wire
